FILE: rtl/sv39pt_pkg.sv
// Shared types, constants and helper functions for the Sv39 page table map engine.
// No dependencies; every other file of the block imports this package.
package sv39pt_pkg;

  // Default sizing
  localparam int unsigned TABLE_PAGES_DEF = 64;
  localparam int unsigned LEVELS_DEF      = 3;

  // Fixed field widths
  localparam int unsigned VA_W     = 39;
  localparam int unsigned PA_W     = 56;
  localparam int unsigned PPN_W    = 44;
  localparam int unsigned ENTRY_W  = 54;
  localparam int unsigned LOC_W    = 15;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned LVL_W    = 2;
  localparam int unsigned PROT_W   = 3;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned ENTRIES  = 512;
  localparam int unsigned PG_SHIFT = 12;

  // Entry flag bits (low byte of an entry)
  localparam logic [7:0] FLAG_V = 8'h01;
  localparam logic [7:0] FLAG_R = 8'h02;
  localparam logic [7:0] FLAG_W = 8'h04;
  localparam logic [7:0] FLAG_X = 8'h08;
  localparam logic [7:0] FLAG_A = 8'h40;
  localparam logic [7:0] FLAG_D = 8'h80;

  // Configuration register indexes
  localparam logic CFG_FREE_BASE  = 1'b0;
  localparam logic CFG_FREE_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] FREE_COUNT_RST = 7'd64;
  localparam logic [PPN_W-1:0] FREE_BASE_RST  = 44'd524288;

  typedef enum logic [1:0] {
    STATUS_MAPPED   = 2'd0,
    STATUS_NO_PAGES = 2'd1,
    STATUS_OUTSIDE  = 2'd2
  } status_e;

  typedef struct packed {
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   target_paddr;
    logic [LVL_W-1:0]  leaf_level;
    logic [PROT_W-1:0] protection;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [LOC_W-1:0]   entry_location;
    logic [CNT_W-1:0]   pages_in_use;
  } rsp_t;

  typedef struct packed {
    logic             reg_index;
    logic [PPN_W-1:0] wr_data;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;    // zero one store word of the reset sweep
    logic load_req;  // capture request, start walk at root
    logic eval;      // act on the entry read for the current level
    logic leaf_wr;   // write the leaf entry, record success
    logic out_load;  // move finished result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;   // sweep at its last word
    logic walk_more;  // current level still above the leaf level
    logic eval_fail;  // entry at hand ends the walk with an error
  } sts_t;

  function automatic logic [7:0] prot_flags(input logic [PROT_W-1:0] prot);
    logic [7:0] f;
    f = '0;
    if (prot[0]) f = f | FLAG_R | FLAG_A;
    if (prot[1]) f = f | FLAG_W | FLAG_D;
    if (prot[2]) f = f | FLAG_X | FLAG_A;
    if (f == '0) f = FLAG_R;
    return f;
  endfunction

  // 9-bit VPN slice for a level; a fourth level lies above bit 38 and reads zero
  function automatic logic [IDX_W-1:0] vpn_index(input logic [VA_W-1:0] va,
                                                 input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[20:12];
      2'd1:    idx = va[29:21];
      2'd2:    idx = va[38:30];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

FILE: rtl/sv39pt_if.sv
// Valid/ready channel interfaces for request, result and configuration words.
// Depends on sv39pt_pkg for the payload types.
interface sv39pt_req_if;
  import sv39pt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sv39pt_rsp_if;
  import sv39pt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sv39pt_cfg_if;
  import sv39pt_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sv39pt_ctrl.sv
// Sequencer of the map engine: reset sweep, walk per level, leaf write, result hand-off.
// Depends on sv39pt_pkg (cmd_t, sts_t).
module sv39pt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output sv39pt_pkg::cmd_t  cmd_o,
  input  sv39pt_pkg::sts_t  sts_i
);
  import sv39pt_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       out_free;

  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_WALK;
        end
      end
      S_WALK: begin
        // read of the level entry is in flight when walking on
        if (sts_i.walk_more) begin
          state_d = S_EVAL;
        end else begin
          cmd_o.leaf_wr = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.eval_fail ? S_DONE : S_WALK;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.out_load) rsp_valid_d = 1'b1;
    else if (rsp_ready_i) rsp_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result register loaded while occupied");

  // registered read data is only used in the cycle after its address was set up
  a_eval_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> $past(state_q) == S_WALK)
    else $error("entry evaluated without a preceding read");

  // no request taken before the store sweep has finished
  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !sts_i.clr_last) |=> !req_ready_o)
    else $error("request port opened during store sweep");

endmodule

FILE: rtl/sv39pt_dp.sv
// Datapath of the map engine: page store, allocator, config registers, walk registers.
// Depends on sv39pt_pkg; driven by sv39pt_ctrl through cmd_t / sts_t.
module sv39pt_dp #(
  parameter int unsigned TABLE_PAGES = sv39pt_pkg::TABLE_PAGES_DEF,
  parameter int unsigned LEVELS      = sv39pt_pkg::LEVELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  sv39pt_pkg::cfg_t  cfg_data_i,
  input  sv39pt_pkg::req_t  req_data_i,
  input  sv39pt_pkg::cmd_t  cmd_i,
  output sv39pt_pkg::sts_t  sts_o,
  output sv39pt_pkg::rsp_t  rsp_data_o
);
  import sv39pt_pkg::*;

  localparam int unsigned SW    = $clog2(TABLE_PAGES);
  localparam int unsigned CW    = $clog2(TABLE_PAGES + 1);
  localparam int unsigned AW    = SW + IDX_W;
  localparam int unsigned DEPTH = TABLE_PAGES * ENTRIES;
  localparam int unsigned CMPW  = (CW > CNT_W) ? CW : CNT_W;
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);
  localparam logic [AW-1:0]    ADDR_LAST = AW'(DEPTH - 1);

  // config and allocator state
  logic [PPN_W-1:0] base_q;
  logic [CNT_W-1:0] count_q;
  logic [CW-1:0]    next_free_q;
  logic [AW-1:0]    clr_cnt_q;

  // request and walk registers
  logic [VA_W-1:0]   va_q;
  logic [PPN_W-1:0]  pa_ppn_q;
  logic [PROT_W-1:0] prot_q;
  logic [LVL_W-1:0]  leaf_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [SW-1:0]     slot_q;

  // result staging and output register
  status_e            res_status_q;
  logic [ENTRY_W-1:0] res_entry_q;
  logic [LOC_W-1:0]   res_loc_q;
  rsp_t               out_q;

  // page store
  logic [ENTRY_W-1:0] table_mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;

  logic [AW-1:0]          walk_addr;
  logic [AW+LOC_W-1:0]    loc_ext;
  logic [CW+CNT_W-1:0]    pages_ext;
  logic                   pte_v;
  logic [PPN_W-1:0]       rel;
  logic                   rel_ok;
  logic                   alloc_ok;
  logic [ENTRY_W-1:0]     new_pte;
  logic [ENTRY_W-1:0]     leaf_entry;
  logic                   eval_wr;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [ENTRY_W-1:0]     mem_wdata;
  logic [LVL_W-1:0]       leaf_in;

  assign walk_addr = {slot_q, vpn_index(va_q, lvl_q)};
  assign loc_ext   = {{LOC_W{1'b0}}, walk_addr};
  assign pages_ext = {{CNT_W{1'b0}}, next_free_q};

  // pointer follow: slot = entry PPN - base, mod 2^44
  assign pte_v  = rd_data_q[0];
  assign rel    = rd_data_q[ENTRY_W-1:10] - base_q;
  assign rel_ok = rel < PPN_W'(TABLE_PAGES);

  // bump allocator bound: configured count and store size
  assign alloc_ok = (CMPW'(next_free_q) < CMPW'(count_q)) &&
                    (next_free_q < CW'(TABLE_PAGES));
  assign new_pte  = {base_q + PPN_W'(next_free_q), 2'b00, FLAG_V};

  assign leaf_entry = {pa_ppn_q, 2'b00, FLAG_V | prot_flags(prot_q)};

  assign eval_wr = cmd_i.eval && !pte_v && alloc_ok;

  assign leaf_in = (req_data_i.leaf_level > LVL_TOP) ? LVL_TOP : req_data_i.leaf_level;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = walk_addr;
    mem_wdata = leaf_entry;
    if (cmd_i.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (eval_wr) begin
      mem_we    = 1'b1;
      mem_wdata = new_pte;
    end else if (cmd_i.leaf_wr) begin
      mem_we = 1'b1;
    end
  end

  assign sts_o.clr_last  = (clr_cnt_q == ADDR_LAST);
  assign sts_o.walk_more = (lvl_q > leaf_q);
  assign sts_o.eval_fail = pte_v ? !rel_ok : !alloc_ok;

  // store: one write port, one registered read port at the walk address
  always_ff @(posedge clk_i) begin
    if (mem_we) table_mem_q[mem_waddr] <= mem_wdata;
    rd_data_q <= table_mem_q[walk_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= FREE_BASE_RST;
      count_q     <= FREE_COUNT_RST;
      next_free_q <= CW'(1);
      clr_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_data_i.reg_index == CFG_FREE_BASE) base_q <= cfg_data_i.wr_data;
        if (cfg_data_i.reg_index == CFG_FREE_COUNT) count_q <= cfg_data_i.wr_data[CNT_W-1:0];
      end
      if (eval_wr) next_free_q <= next_free_q + CW'(1);
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      va_q     <= req_data_i.virt_addr;
      pa_ppn_q <= req_data_i.target_paddr[PA_W-1:PG_SHIFT];
      prot_q   <= req_data_i.protection;
      leaf_q   <= leaf_in;
      lvl_q    <= LVL_TOP;
      slot_q   <= '0;
    end
    if (cmd_i.eval) begin
      lvl_q <= lvl_q - LVL_W'(1);
      if (pte_v) slot_q <= rel[SW-1:0];
      else slot_q <= next_free_q[SW-1:0];
      if (sts_o.eval_fail) begin
        res_status_q <= pte_v ? STATUS_OUTSIDE : STATUS_NO_PAGES;
        res_entry_q  <= '0;
        res_loc_q    <= '0;
      end
    end
    if (cmd_i.leaf_wr) begin
      res_status_q <= STATUS_MAPPED;
      res_entry_q  <= leaf_entry;
      res_loc_q    <= loc_ext[LOC_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.status         <= res_status_q;
      out_q.leaf_entry     <= res_entry_q;
      out_q.entry_location <= res_loc_q;
      out_q.pages_in_use   <= pages_ext[CNT_W-1:0];
    end
  end

  assign rsp_data_o = out_q;

  // allocator never passes the store size
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= CW'(TABLE_PAGES))
    else $error("allocator beyond store");

  // one writer per cycle
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.clr_wr, eval_wr, cmd_i.leaf_wr}))
    else $error("store write conflict");

  // leaf goes in at the leaf level only
  a_leaf_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.leaf_wr |-> (lvl_q == leaf_q))
    else $error("leaf written at wrong level");

  // a successful step always lands on a slot inside the store
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && !sts_o.eval_fail) |=> (CW'(slot_q) < CW'(TABLE_PAGES)))
    else $error("walk left the store");

endmodule

FILE: rtl/sv39_page_table_map_engine.sv
// Sv39 page table map engine, top level. One request in flight: a new word is taken
// once the last result has moved into the output register. The walk covers n = table
// levels above the leaf (0..LEVELS-1) on the single store port: one registered read and
// at most one write per level, then the leaf write.
// Reset: a sweep zeroes all TABLE_PAGES*512 words of the page store (32768 by default),
// with the request port held not ready; config writes are taken throughout.
//
// Depends on sv39pt_pkg, sv39pt_if, sv39pt_ctrl, sv39pt_dp.
module sv39_page_table_map_engine #(
  parameter int unsigned TABLE_PAGES = sv39pt_pkg::TABLE_PAGES_DEF,
  parameter int unsigned LEVELS      = sv39pt_pkg::LEVELS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sv39pt_req_if.sink    req_i,
  sv39pt_rsp_if.source  rsp_o,
  sv39pt_cfg_if.sink    cfg_i
);
  import sv39pt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Config registers are plain flops in the datapath; a write lands in the next cycle.
  assign cfg_i.ready = 1'b1;

  // Controller: sweep after reset, then per request:
  //   IDLE -> (WALK -> EVAL) per level above the leaf -> WALK (leaf write) -> DONE.
  // An invalid entry on the path takes the next free slot and gets a pointer entry, failing
  // if none is left; a valid one is followed, failing when its PPN lies outside the store.
  sv39pt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: page store, bump allocator, walk and result registers.
  // The result sits in its own output register, so the next request is taken
  // while a finished word still waits on the result side.
  sv39pt_dp #(
    .TABLE_PAGES (TABLE_PAGES),
    .LEVELS      (LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .req_data_i  (req_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_data_o  (rsp_o.data)
  );

endmodule

FILE: verif/sv39_page_table_map_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Sv39 page table map engine: directed table, then random phases.
// Depends on sv39pt_pkg, the sv39pt channel interfaces and the engine RTL.
module sv39_page_table_map_engine_tb;
  import sv39pt_pkg::*;

  localparam int N_PAGES      = TABLE_PAGES_DEF;
  localparam int N_LEVELS     = LEVELS_DEF;
  localparam int STORE_WORDS  = N_PAGES * ENTRIES;
  localparam int PTE_PPN_LSB  = 10;
  // Reset sweep alone covers 32768 store words; ~1500 request words come on top.
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 250;

  logic clk_i;
  logic rst_ni;

  sv39pt_req_if req_ch ();
  sv39pt_rsp_if rsp_ch ();
  sv39pt_cfg_if cfg_ch ();

  sv39_page_table_map_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the engine: page store, allocator and both registers
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] pt_store [STORE_WORDS];
  int                 pages_used;   // next slot the bump allocator hands out
  logic [PPN_W-1:0]   base_ppn;
  logic [CNT_W-1:0]   page_limit;

  rsp_t due_results [$];            // expected result words, oldest first
  int   mismatches  = 0;
  int   results_seen = 0;
  int   cycles      = 0;
  int   req_burst   = 0;            // words left in a no-gap stretch, request side
  int   rsp_burst   = 0;            // same, result side

  // One directed row: either a map request or a register update.
  typedef struct {
    logic             is_cfg;
    req_t             req;
    logic             given;        // expectation typed into the row
    rsp_t             rsp;
    logic [PPN_W-1:0] cfg_base;
    logic [CNT_W-1:0] cfg_count;
  } row_t;

  row_t directed_rows [$];

  function automatic logic [IDX_W-1:0] vpn_slice(input logic [VA_W-1:0] va, input int lvl);
    return va[PG_SHIFT + IDX_W*lvl +: IDX_W];
  endfunction

  function automatic logic [7:0] perm_bits(input logic [PROT_W-1:0] p);
    logic [7:0] b;
    b = (p[0] ? (FLAG_R | FLAG_A) : 8'h00) |
        (p[1] ? (FLAG_W | FLAG_D) : 8'h00) |
        (p[2] ? (FLAG_X | FLAG_A) : 8'h00);
    return (b == 8'h00) ? FLAG_R : b;
  endfunction

  // Walk the shadow table for one request, allocating pointer pages on the way,
  // and return the result word the engine should send back.
  function automatic rsp_t map_page(input req_t r);
    rsp_t               res;
    int                 leaf;
    int                 lvl;
    int                 slot;
    int                 w;
    logic [ENTRY_W-1:0] pte;
    logic [PPN_W-1:0]   rel;
    logic               stop;
    res        = '0;
    res.status = STATUS_MAPPED;
    leaf       = int'(r.leaf_level);
    if (leaf > N_LEVELS - 1) leaf = N_LEVELS - 1;   // leaf level above the top clamps to root
    slot = 0;
    stop = 1'b0;
    for (lvl = N_LEVELS - 1; lvl > leaf && !stop; lvl--) begin
      w   = slot * ENTRIES + int'(vpn_slice(r.virt_addr, lvl));
      pte = pt_store[w];
      if (!pte[0]) begin
        if (pages_used >= int'(page_limit) || pages_used >= N_PAGES) begin
          res.status = STATUS_NO_PAGES;
          stop       = 1'b1;
        end else begin
          pte = {base_ppn + PPN_W'(pages_used), 10'h000} | ENTRY_W'(FLAG_V);
          pt_store[w] = pte;
          pages_used++;
        end
      end
      // any valid entry is followed as a pointer, leaves included
      if (!stop) begin
        rel = pte[PTE_PPN_LSB + PPN_W - 1:PTE_PPN_LSB] - base_ppn;
        if (rel >= N_PAGES) begin
          res.status = STATUS_OUTSIDE;
          stop       = 1'b1;
        end else begin
          slot = int'(rel);
        end
      end
    end
    if (!stop) begin
      w = slot * ENTRIES + int'(vpn_slice(r.virt_addr, leaf));
      res.leaf_entry     = {r.target_paddr[PA_W-1:PG_SHIFT], 10'h000} |
                           ENTRY_W'(FLAG_V | perm_bits(r.protection));
      res.entry_location = w[LOC_W-1:0];
      pt_store[w]        = res.leaf_entry;
    end
    res.pages_in_use = pages_used[CNT_W-1:0];
    return res;
  endfunction

  function automatic row_t req_row(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                                   input logic [LVL_W-1:0] lvl, input logic [PROT_W-1:0] prot);
    row_t row;
    row     = '{default: '0};
    row.req = '{virt_addr: va, target_paddr: pa, leaf_level: lvl, protection: prot};
    return row;
  endfunction

  function automatic row_t given_row(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                                     input logic [LVL_W-1:0] lvl,
                                     input logic [PROT_W-1:0] prot, input status_e st,
                                     input logic [ENTRY_W-1:0] pte,
                                     input logic [LOC_W-1:0] loc,
                                     input logic [CNT_W-1:0] pages);
    row_t row;
    row       = req_row(va, pa, lvl, prot);
    row.given = 1'b1;
    row.rsp   = '{status: st, leaf_entry: pte, entry_location: loc, pages_in_use: pages};
    return row;
  endfunction

  function automatic row_t cfg_row(input logic [PPN_W-1:0] nb, input logic [CNT_W-1:0] nc);
    row_t row;
    row           = '{default: '0};
    row.is_cfg    = 1'b1;
    row.cfg_base  = nb;
    row.cfg_count = nc;
    return row;
  endfunction

  // Draw the wait before the next word; now and then a stretch of words goes with none.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  // Present one request word; the expectation is queued on acceptance.
  task automatic issue_map(input req_t r, input logic given, input rsp_t fixed);
    int   gap;
    rsp_t pred;
    gap = draw_wait(req_burst);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    pred = map_page(r);   // shadow state moves even when the row carries its own answer
    due_results.push_back(given ? fixed : pred);
  endtask

  // Hold off requests until every outstanding result has come back.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // Both registers, back to back with valid held high.
  task automatic write_config(input logic [PPN_W-1:0] nb, input logic [CNT_W-1:0] nc);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{reg_index: CFG_FREE_BASE, wr_data: nb};
    do @(posedge clk_i); while (!cfg_ch.ready);
    base_ppn = nb;
    cfg_ch.data <= '{reg_index: CFG_FREE_COUNT, wr_data: {{(PPN_W-CNT_W){1'b0}}, nc}};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    page_limit = nc;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, each word checked against the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int   stall;
    rsp_t got;
    rsp_t want;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(rsp_burst);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      got = rsp_ch.data;
      results_seen++;
      if (due_results.size() == 0) begin
        flag_mismatch("result word with no request pending");
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status)
          flag_mismatch($sformatf("status got %0d expected %0d", got.status, want.status));
        if (got.leaf_entry !== want.leaf_entry)
          flag_mismatch($sformatf("leaf_entry got %0h expected %0h",
                                  got.leaf_entry, want.leaf_entry));
        if (got.entry_location !== want.entry_location)
          flag_mismatch($sformatf("entry_location got %0d expected %0d",
                                  got.entry_location, want.entry_location));
        if (got.pages_in_use !== want.pages_in_use)
          flag_mismatch($sformatf("pages_in_use got %0d expected %0d",
                                  got.pages_in_use, want.pages_in_use));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int               phase;
    int               k;
    int               sel;
    req_t             r;
    logic [IDX_W-1:0] hi_pool  [8];
    logic [IDX_W-1:0] mid_pool [6];
    logic [PPN_W-1:0] spare_base;
    logic [PPN_W-1:0] nb;
    logic [CNT_W-1:0] nc;

    rst_ni       <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;

    foreach (pt_store[i]) pt_store[i] = '0;
    pages_used = 1;                 // root owns slot 0
    base_ppn   = FREE_BASE_RST;
    page_limit = FREE_COUNT_RST;

    // Directed rows. Reset registers apply until the first config row.
    // Fresh walk from reset: slots 1 and 2 handed out, empty protection gives R.
    directed_rows.push_back(given_row('0, '0, 2'd0, 3'd0, STATUS_MAPPED,
                                      54'h3, 15'd1024, 7'd3));
    // All-ones corners: top index at every level, every permission bit.
    directed_rows.push_back(given_row('1, '1, 2'd0, 3'd7, STATUS_MAPPED,
                                      {44'hFFF_FFFF_FFFF, 10'h0CF}, 15'd2559, 7'd5));
    // Leaf level 3 clamps to the root; overwrites the root pointer at index 0.
    directed_rows.push_back(given_row('0, '0, 2'd3, 3'd1, STATUS_MAPPED,
                                      54'h43, 15'd0, 7'd5));
    // That leaf now sits on the path with PPN 0, far below the store base.
    directed_rows.push_back(given_row('0, 56'h0_0000_004D_2000, 2'd1, 3'd2, STATUS_OUTSIDE,
                                      '0, '0, 7'd5));
    // 1 GiB leaf whose PPN lands inside the store (slot 1), then walked through.
    directed_rows.push_back(req_row({9'd7, 9'd0, 9'd0, 12'h000},
                                    {FREE_BASE_RST + 44'd1, 12'h000}, 2'd2, 3'd4));
    directed_rows.push_back(req_row({9'd7, 9'd3, 9'd9, 12'hABC},
                                    56'h12_3456_789A_BCDE, 2'd0, 3'd3));
    directed_rows.push_back(req_row({9'd2, 9'd1, 9'd0, 12'h000},
                                    56'h00_0000_1234_5000, 2'd1, 3'd5));
    directed_rows.push_back(req_row({9'd2, 9'd2, 9'd0, 12'h000},
                                    56'hFF_0000_0000_0FFF, 2'd1, 3'd6));
    directed_rows.push_back(req_row({9'd2, 9'd3, 9'd4, 12'h001},
                                    56'h80_0000_0000_1000, 2'd0, 3'd2));
    directed_rows.push_back(req_row({9'd2, 9'd3, 9'd5, 12'h002},
                                    56'h7F_FFFF_FFFF_F000, 2'd0, 3'd4));
    directed_rows.push_back(req_row({9'd511, 9'd0, 9'd0, 12'h000}, '0, 2'd2, 3'd7));
    // Allocator closed: any fresh page fails.
    directed_rows.push_back(cfg_row(FREE_BASE_RST, 7'd1));
    directed_rows.push_back(req_row({9'd100, 9'd4, 9'd1, 12'h000},
                                    56'h00_0000_0000_1000, 2'd0, 3'd1));
    // One page left: the walk grabs it and fails one level down; the pointer stays.
    directed_rows.push_back(cfg_row(FREE_BASE_RST, 7'd9));
    directed_rows.push_back(req_row({9'd100, 9'd4, 9'd1, 12'h000},
                                    56'h00_0000_0000_2000, 2'd0, 3'd1));
    directed_rows.push_back(req_row({9'd100, 9'd4, 9'd1, 12'h000},
                                    56'h00_0000_0000_3000, 2'd1, 3'd3));
    // Base at the top of the PPN range: new pointer PPNs wrap to low values.
    directed_rows.push_back(cfg_row('1, FREE_COUNT_RST));
    directed_rows.push_back(req_row({9'd300, 9'd5, 9'd6, 12'h000},
                                    56'h00_0000_0000_4000, 2'd0, 3'd1));
    directed_rows.push_back(req_row({9'd2, 9'd3, 9'd4, 12'h000},
                                    56'h00_0000_0000_5000, 2'd0, 3'd1));
    // Base 0: the PPN-0 leaf in root now resolves to slot 0 itself.
    directed_rows.push_back(cfg_row('0, FREE_COUNT_RST));
    directed_rows.push_back(req_row('0, 56'h00_0000_0000_6000, 2'd0, 3'd5));
    directed_rows.push_back(req_row({9'd0, 9'd5, 9'd7, 12'h000},
                                    56'h00_0000_0000_7000, 2'd0, 3'd6));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        write_config(directed_rows[i].cfg_base, directed_rows[i].cfg_count);
      end else begin
        issue_map(directed_rows[i].req, directed_rows[i].given, directed_rows[i].rsp);
      end
    end

    // Small index pools so random walks keep meeting the same table pages.
    hi_pool[0]  = '0;
    hi_pool[1]  = '1;
    mid_pool[0] = '0;
    mid_pool[1] = '1;
    for (k = 2; k < 8; k++) hi_pool[k] = IDX_W'($urandom);
    for (k = 2; k < 6; k++) mid_pool[k] = IDX_W'($urandom);
    spare_base = PPN_W'({$urandom, $urandom});

    for (phase = 0; phase < PHASES; phase++) begin
      // registers only change with nothing in flight
      wait_idle();
      if (phase == 0) begin
        nb = FREE_BASE_RST;
        nc = FREE_COUNT_RST;
      end else begin
        case ($urandom_range(0, 3))
          0:       nb = FREE_BASE_RST;
          1:       nb = '0;
          2:       nb = '1;
          default: nb = spare_base;
        endcase
        sel = $urandom_range(0, 3);
        nc  = (sel < 2) ? FREE_COUNT_RST : (sel == 2) ? 7'd1 : CNT_W'($urandom_range(1, 64));
      end
      write_config(nb, nc);

      for (k = 0; k < PHASE_WORDS; k++) begin
        // mostly pooled prefixes with random low index and offset, some pure noise
        sel = $urandom_range(0, 9);
        if (sel < 7)
          r.virt_addr = {hi_pool[$urandom_range(0, 7)], mid_pool[$urandom_range(0, 5)],
                         IDX_W'($urandom), 12'($urandom)};
        else
          r.virt_addr = VA_W'({$urandom, $urandom});
        // some leaves get a PPN near the base so later walks follow them as pointers
        if ($urandom_range(0, 4) == 0)
          r.target_paddr = {base_ppn + PPN_W'($urandom_range(0, 70)), 12'($urandom)};
        else
          r.target_paddr = PA_W'({$urandom, $urandom});
        sel          = $urandom_range(0, 19);
        r.leaf_level = (sel < 10) ? 2'd0 : (sel < 15) ? 2'd1 : (sel < 18) ? 2'd2 : 2'd3;
        r.protection = PROT_W'($urandom);
        issue_map(r, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);   // catch any stray extra word
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: sv39_page_table_map_engine.f
rtl/sv39pt_pkg.sv
rtl/sv39pt_if.sv
rtl/sv39pt_ctrl.sv
rtl/sv39pt_dp.sv
rtl/sv39_page_table_map_engine.sv
verif/sv39_page_table_map_engine_tb.sv
